FILE: design/assert_macros.svh
// Assertion macros used by knn_label_majority_vote.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/knnv_pkg.sv
// Shared types and constants of the nearest-neighbour label vote.
// No dependencies; imported by knnv_lookup and knn_label_majority_vote.
`timescale 1ns / 1ps

package knnv_pkg;

    // Table depth and derived index width
    localparam int MAX_QUORUM = 16;
    localparam int IDX_W      = (MAX_QUORUM > 1) ? $clog2(MAX_QUORUM) : 1;

    // Field widths
    localparam int LABEL_W = 32;
    localparam int COUNT_W = 5;

    typedef logic signed [LABEL_W-1:0] label_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [IDX_W-1:0]          idx_t;

    // Saturation ceiling of a vote count and the empty-result label
    localparam count_t COUNT_MAX = '1;
    localparam label_t NO_LABEL  = '1;

    // One neighbour transfer
    typedef struct packed {
        logic   neighbour_found;
        label_t neighbour_label;
        logic   last_neighbour;
    } nbr_item_t;

    // One vote result transfer
    typedef struct packed {
        label_t winning_label;
        count_t winning_votes;
        logic   table_overflow;
    } vote_item_t;

    // Table lookup outcome for one label
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free_avail;
        idx_t free_idx;
    } lookup_t;

endpackage

FILE: design/knn_label_majority_vote.sv
// Top level of the nearest-neighbour label majority vote.
// Depends on knnv_pkg, knnv_lookup and assert_macros.svh.
//
// Channel     | Direction | Payload      | Transfer
// ------------+-----------+--------------+-----------------------------------
// neighbour   | in        | nbr_item_t   | neighbour_valid && neighbour_ready
// result      | out       | vote_item_t  | result_valid && result_ready
//
// One neighbour is taken every cycle unless a last neighbour is held; each is
// voted as it leaves the input register, by one parallel compare against the
// 16-entry table and one count update, and a last neighbour's result sits in
// the output register the cycle after its vote. Reset clears the valid bits,
// counts and winner at once, with no sweep. A last neighbour waits in the
// input register while an earlier result is still untaken; others never stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knn_label_majority_vote (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   neighbour_valid,
    output logic                   neighbour_ready,
    input  knnv_pkg::nbr_item_t    neighbour,
    output logic                   result_valid,
    input  logic                   result_ready,
    output knnv_pkg::vote_item_t   result
);
    import knnv_pkg::*;

    // Input register
    logic       pipe_vld_reg;
    nbr_item_t  pipe_reg;
    logic       advance;

    // Vote table and running winner
    label_t                  label_reg  [MAX_QUORUM];
    count_t                  count_reg  [MAX_QUORUM];
    count_t                  count_next [MAX_QUORUM];
    logic [MAX_QUORUM-1:0]   valid_reg;
    logic [MAX_QUORUM-1:0]   valid_next;
    count_t                  best_count_reg;
    count_t                  best_count_next;
    label_t                  best_label_reg;
    label_t                  best_label_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    label_we;
    count_t                  bumped_count;
    lookup_t                 lookup;

    // Result register
    logic       res_vld_reg;
    vote_item_t res_reg;
    vote_item_t res_next;

    // Move the held item on unless it closes a query and the result slot is busy
    assign advance = pipe_vld_reg &&
                     (!pipe_reg.last_neighbour || !res_vld_reg || result_ready);
    assign neighbour_ready = !pipe_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= 1'b0;
        end
        else if (neighbour_ready)
        begin
            pipe_vld_reg <= neighbour_valid;
        end
    end

    // Capture the payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (neighbour_valid && neighbour_ready)
        begin
            pipe_reg <= neighbour;
        end
    end

    knnv_lookup u_lookup (
        .labels (label_reg),
        .valid  (valid_reg),
        .query  (pipe_reg.neighbour_label),
        .lookup (lookup)
    );

    // Cast the vote, form the result, then clear at the end of a query
    always_comb
    begin
        count_next      = count_reg;
        valid_next      = valid_reg;
        best_count_next = best_count_reg;
        best_label_next = best_label_reg;
        ovf_next        = ovf_reg;
        label_we        = 1'b0;
        bumped_count    = count_reg[lookup.hit_idx] + count_t'(1);

        if (advance && pipe_reg.neighbour_found)
        begin
            if (lookup.hit)
            begin
                if (count_reg[lookup.hit_idx] != COUNT_MAX)
                begin
                    count_next[lookup.hit_idx] = bumped_count;
                    if (bumped_count > best_count_reg)
                    begin
                        best_count_next = bumped_count;
                        best_label_next = pipe_reg.neighbour_label;
                    end
                end
            end
            else if (lookup.free_avail)
            begin
                label_we                    = 1'b1;
                valid_next[lookup.free_idx] = 1'b1;
                count_next[lookup.free_idx] = count_t'(1);
                if (best_count_reg == '0)
                begin
                    best_count_next = count_t'(1);
                    best_label_next = pipe_reg.neighbour_label;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (best_count_next == '0)
        begin
            res_next.winning_label = NO_LABEL;
            res_next.winning_votes = '0;
        end
        else
        begin
            res_next.winning_label = best_label_next;
            res_next.winning_votes = best_count_next;
        end
        res_next.table_overflow = ovf_next;

        if (advance && pipe_reg.last_neighbour)
        begin
            valid_next      = '0;
            best_count_next = '0;
            best_label_next = NO_LABEL;
            ovf_next        = 1'b0;
            for (int i = 0; i < MAX_QUORUM; i++)
            begin
                count_next[i] = '0;
            end
        end
    end

    // Table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            best_count_reg <= '0;
            best_label_reg <= NO_LABEL;
            ovf_reg        <= 1'b0;
            for (int i = 0; i < MAX_QUORUM; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg      <= valid_next;
            best_count_reg <= best_count_next;
            best_label_reg <= best_label_next;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
        end
    end

    // Write a new label into its free entry
    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_reg[lookup.free_idx] <= pipe_reg.neighbour_label;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance && pipe_reg.last_neighbour)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pipe_reg.last_neighbour)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // Checks on the vote logic
    `ASSERT_IMPLIES(a_no_votes_no_label, clk, rst_n, best_count_reg == '0, best_label_reg == NO_LABEL)
    `ASSERT_IMPLIES(a_empty_table_no_best, clk, rst_n, valid_reg == '0, best_count_reg == '0)
    `ASSERT_IMPLIES(a_overflow_when_full, clk, rst_n, ovf_reg, &valid_reg)
    `ASSERT_NEXT(a_last_clears_and_reports, clk, rst_n, advance && pipe_reg.last_neighbour, res_vld_reg && (valid_reg == '0))

endmodule

FILE: design/knnv_lookup.sv
// Parallel label lookup: first matching valid entry and first free entry.
// Depends on knnv_pkg.
`timescale 1ns / 1ps

module knnv_lookup (
    input  knnv_pkg::label_t                     labels [knnv_pkg::MAX_QUORUM],
    input  logic [knnv_pkg::MAX_QUORUM-1:0]      valid,
    input  knnv_pkg::label_t                     query,
    output knnv_pkg::lookup_t                    lookup
);
    import knnv_pkg::*;

    // Compare all entries at once; scan downward so the lowest index wins
    always_comb
    begin
        lookup = '0;
        for (int i = MAX_QUORUM - 1; i >= 0; i--)
        begin
            if (valid[i] && (labels[i] == query))
            begin
                lookup.hit     = 1'b1;
                lookup.hit_idx = idx_t'(i);
            end
            if (!valid[i])
            begin
                lookup.free_avail = 1'b1;
                lookup.free_idx   = idx_t'(i);
            end
        end
    end

endmodule
